FILE: rtl/core/oltab_pkg.sv
`timescale 1ns / 1ps

package oltab_pkg;

  localparam int OUT_CNT_W = 7;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_COUNT  = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic walk;
    logic commit;
  } oltab_cmd_t;

  typedef struct packed {
    logic walk_busy;
  } oltab_status_t;

endpackage

FILE: rtl/core/oltab_ctrl.sv
`timescale 1ns / 1ps

module oltab_ctrl import oltab_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output oltab_cmd_t    cmd,
  input  oltab_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;

  assign cmd.load   = in_valid && (state_r == S_IDLE);
  assign cmd.setup  = (state_r == S_SETUP);
  assign cmd.walk   = (state_r == S_WALK);
  // result word loads only once the output register is free
  assign cmd.commit = (state_r == S_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_COMMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (!status.walk_busy) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/oltab_dp.sv
`timescale 1ns / 1ps

module oltab_dp import oltab_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  oltab_cmd_t           cmd,
  output oltab_status_t        status,
  input  logic [2:0]           in_action,
  input  logic signed [31:0]   in_value,
  input  logic [7:0]           in_position,
  output logic                 out_ok,
  output logic signed [31:0]   out_read_value,
  output logic [OUT_CNT_W-1:0] out_index_or_count,
  output logic [OUT_CNT_W-1:0] out_list_length
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int OW     = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  logic [31:0] mem [CAPACITY];

  // captured item
  logic [2:0]         act_r;
  logic signed [31:0] val_r;
  logic [7:0]         pos_r;

  // decoded action
  logic             ok_r, ins_r, del_r, find_r, read_r, up_r, dn_r, scan_r;
  logic [CNT_W-1:0] slot_r;

  // walk
  logic             iss_r, pend_r, hit_r;
  logic [CNT_W-1:0] ptr_r, lim_r, pend_addr_r, acc_r, count_r;
  logic [31:0]      rdata_r;

  // decode
  logic [CW-1:0]    slot_e, pos_e, cnt_e, cap_e;
  logic             d_ok, d_ins, d_del, d_find, d_read, d_up, d_dn, d_scan, d_walk;
  logic [CNT_W-1:0] d_ptr, d_lim, d_slot;

  logic             stop, issue;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [CNT_W-1:0] step_addr, count_nxt;
  logic [OW-1:0]    acc_ext, cnt_ext;

  assign pos_e  = CW'(pos_r);
  assign cnt_e  = CW'(count_r);
  assign cap_e  = CW'(CAPACITY);
  assign slot_e = (pos_r == 8'd0) ? '0 : (pos_e - CW'(1));

  always_comb begin
    d_ok   = 1'b0;
    d_ins  = 1'b0;
    d_del  = 1'b0;
    d_find = 1'b0;
    d_read = 1'b0;
    d_up   = 1'b0;
    d_dn   = 1'b0;
    d_scan = 1'b0;
    d_walk = 1'b0;
    d_ptr  = '0;
    d_lim  = '0;
    d_slot = slot_e[CNT_W-1:0];
    case (act_r)
      ACT_INSERT: begin
        if (cnt_e < cap_e && slot_e <= cnt_e) begin
          d_ok  = 1'b1;
          d_ins = 1'b1;
          if (slot_e < cnt_e) begin
            d_walk = 1'b1;
            d_up   = 1'b1;
            d_ptr  = count_r - CNT_W'(1);
            d_lim  = slot_e[CNT_W-1:0];
          end
        end
      end
      ACT_APPEND: begin
        d_slot = count_r;
        if (cnt_e < cap_e) begin
          d_ok  = 1'b1;
          d_ins = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (slot_e < cnt_e) begin
          d_ok  = 1'b1;
          d_del = 1'b1;
          if (slot_e + CW'(1) < cnt_e) begin
            d_walk = 1'b1;
            d_dn   = 1'b1;
            d_ptr  = slot_e[CNT_W-1:0] + CNT_W'(1);
            d_lim  = count_r - CNT_W'(1);
          end
        end
      end
      ACT_FIND, ACT_COUNT: begin
        d_find = (act_r == ACT_FIND);
        d_ok   = (act_r == ACT_COUNT);
        d_scan = 1'b1;
        if (count_r != '0) begin
          d_walk = 1'b1;
          d_ptr  = '0;
          d_lim  = count_r - CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (pos_r != 8'd0 && pos_e <= cnt_e) begin
          d_ok   = 1'b1;
          d_read = 1'b1;
          d_walk = 1'b1;
          d_ptr  = slot_e[CNT_W-1:0];
          d_lim  = slot_e[CNT_W-1:0];
        end
      end
      default: begin
        d_ok = 1'b0;
      end
    endcase
  end

  // find stops issuing reads once the first match is seen
  assign stop  = find_r && hit_r;
  assign issue = cmd.walk && iss_r && !stop;
  assign status.walk_busy = (iss_r && !stop) || pend_r;

  assign step_addr = up_r ? (pend_addr_r + CNT_W'(1)) : (pend_addr_r - CNT_W'(1));
  assign wr_en     = (cmd.walk && pend_r && (up_r || dn_r)) || (cmd.commit && ins_r);
  assign wr_addr   = cmd.commit ? slot_r[ADDR_W-1:0] : step_addr[ADDR_W-1:0];
  assign wr_data   = cmd.commit ? val_r : rdata_r;

  always_comb begin
    count_nxt = count_r;
    if (ins_r) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_r) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign acc_ext = OW'(acc_r);
  assign cnt_ext = OW'(count_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_r <= mem[ptr_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.setup) begin
      ok_r   <= d_ok;
      ins_r  <= d_ins;
      del_r  <= d_del;
      find_r <= d_find;
      read_r <= d_read;
      up_r   <= d_up;
      dn_r   <= d_dn;
      scan_r <= d_scan;
      slot_r <= d_slot;
      ptr_r  <= d_ptr;
      lim_r  <= d_lim;
      acc_r  <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.walk) begin
      if (issue) begin
        pend_addr_r <= ptr_r;
        if (up_r) begin
          ptr_r <= ptr_r - CNT_W'(1);
        end else begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
      end
      if (pend_r && scan_r && !stop && rdata_r == val_r) begin
        if (find_r) begin
          hit_r <= 1'b1;
          acc_r <= pend_addr_r + CNT_W'(1);
        end else begin
          acc_r <= acc_r + CNT_W'(1);
        end
      end
    end
    if (cmd.commit) begin
      out_ok             <= ok_r || (find_r && hit_r);
      out_read_value     <= read_r ? rdata_r : '0;
      out_index_or_count <= scan_r ? acc_ext[OUT_CNT_W-1:0] : '0;
      out_list_length    <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (cmd.setup) begin
        iss_r  <= d_walk;
        pend_r <= 1'b0;
      end else if (cmd.walk) begin
        pend_r <= issue;
        if (issue && ptr_r == lim_r) begin
          iss_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/ordered_list_table_engine.sv
`timescale 1ns / 1ps
// An accepted word passes through the setup, walk and commit states before out_valid; in the
// walk, n elements (up to CAPACITY) are read, one per cycle through the read port.
// A new word is taken only after the previous result is committed; in_ready is high
// only while the engine is idle.
// A finished result waits in the output register; the next word is taken meanwhile.
// Reset (synchronous, rst_n low) empties the list; store contents are left as they were.

module ordered_list_table_engine import oltab_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_action,
  input  logic signed [31:0]   in_value,
  input  logic [7:0]           in_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ok,
  output logic signed [31:0]   out_read_value,
  output logic [OUT_CNT_W-1:0] out_index_or_count,
  output logic [OUT_CNT_W-1:0] out_list_length
);

  oltab_cmd_t    cmd;
  oltab_status_t status;

  oltab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  oltab_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_action          (in_action),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_index_or_count (out_index_or_count),
    .out_list_length    (out_list_length)
  );

endmodule
